[hw/rtl/ptlc_pkg.sv]
// ----------------------------------------------------------------------------
// ptlc_pkg
// Shared types, constants and the microcode table of the pan/tilt lag
// compensator.
// ----------------------------------------------------------------------------
package ptlc_pkg;

  // Channel payloads
  typedef struct packed {
    logic               mode;
    logic signed [15:0] pan_angle;
    logic signed [15:0] tilt_angle;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pan_value;
    logic [15:0] tilt_value;
    logic [8:0]  first_slot;
  } out_item_t;

  // Item modes
  localparam logic MODE_MOVE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAN_AMPLITUDE = 3'd0,
    CFG_PAN_GAIN      = 3'd1,
    CFG_TILT_GAIN     = 3'd2,
    CFG_COMP_ENABLE   = 3'd3,
    CFG_START_SLOT    = 3'd4
  } cfg_reg_e;

  // Angle limits in 1/32 degree
  localparam logic signed [15:0] PAN_ANGLE_MAX  = 16'sd11520;
  localparam logic signed [16:0] TILT_SPAN      = 17'sd5760;
  localparam logic signed [16:0] TILT_HALF_SPAN = 17'sd2880;

  // Scaling constants
  // Divide by 45 as multiply by ceil(2^28/45), exact for 22-bit dividends
  localparam logic [23:0] RECIP_45    = 24'd5965233;
  localparam int unsigned RECIP_SHIFT = 28;
  localparam logic [23:0] TILT_SCALE  = 24'd27330;
  // 32768*2880 - 2880*27330: offset once the tilt angle is biased by 2880
  localparam logic [27:0] TILT_OFFSET = 28'd15661440;
  localparam logic [15:0] ROUND_HALF  = 16'd32768;
  localparam logic [15:0] TILT_CENTRE = 16'd32768;

  // Multiplier width and chunk split of the lag magnitude
  localparam int unsigned MUL_W   = 24;
  localparam int unsigned PROD_W  = 2 * MUL_W;

  // Microcode
  localparam int unsigned UPC_W = 5;

  typedef enum logic [2:0] {
    MS_NONE,
    MS_PAN_AMP,
    MS_Y_RECIP,
    MS_TILT_SCALE,
    MS_Z_RECIP,
    MS_MAG_LO,
    MS_MAG_HI
  } mul_sel_e;

  typedef enum logic [1:0] {
    AO_NONE,
    AO_TILT_OFS,
    AO_ROUND,
    AO_ADD_HI
  } acc_op_e;

  typedef enum logic [2:0] {
    XO_NONE,
    XO_PAN_TGT,
    XO_TILT_TGT,
    XO_ABS,
    XO_UPDATE,
    XO_OUTPUT,
    XO_LOAD_TGT
  } ex_op_e;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_TICK,
    JC_COMP_ON,
    JC_COMP_OFF
  } jump_e;

  typedef struct packed {
    mul_sel_e         mul_sel;
    acc_op_e          acc_op;
    ex_op_e           ex_op;
    logic             axis;
    jump_e            jump;
    logic [UPC_W-1:0] target;
    logic             emit;
    logic             finish;
  } ucode_t;

  localparam logic AX_PAN  = 1'b0;
  localparam logic AX_TILT = 1'b1;

  // Entry points
  localparam logic [UPC_W-1:0] UPC_TICK  = 5'd8;
  localparam logic [UPC_W-1:0] UPC_EMIT  = 5'd21;
  localparam logic [UPC_W-1:0] UPC_QUIET = 5'd22;
  localparam logic [UPC_W-1:0] UPC_NONE  = 5'd0;

  function automatic ucode_t uc_word(mul_sel_e ms, acc_op_e ao, ex_op_e xo, logic ax,
                                     jump_e jc, logic [UPC_W-1:0] tgt, logic em,
                                     logic fin);
    ucode_t w;
    w.mul_sel = ms;
    w.acc_op  = ao;
    w.ex_op   = xo;
    w.axis    = ax;
    w.jump    = jc;
    w.target  = tgt;
    w.emit    = em;
    w.finish  = fin;
    return w;
  endfunction

  // Program: move scaling, lag step for pan then tilt, result hand-off
  function automatic ucode_t ucode_rom(logic [UPC_W-1:0] pc);
    ucode_t w;
    case (pc)
      // dispatch on item mode
      5'd0:  w = uc_word(MS_NONE, AO_NONE, XO_NONE, AX_PAN, JC_TICK, UPC_TICK, 1'b0, 1'b0);
      // pan target = floor(floor(p*amp/256)/45)
      5'd1:  w = uc_word(MS_PAN_AMP, AO_NONE, XO_NONE, AX_PAN, JC_NEXT, UPC_NONE, 1'b0,
                         1'b0);
      5'd2:  w = uc_word(MS_Y_RECIP, AO_NONE, XO_NONE, AX_PAN, JC_NEXT, UPC_NONE, 1'b0,
                         1'b0);
      5'd3:  w = uc_word(MS_TILT_SCALE, AO_NONE, XO_PAN_TGT, AX_PAN, JC_NEXT, UPC_NONE,
                         1'b0, 1'b0);
      // tilt target = floor(floor((27330*u + offset)/64)/45)
      5'd4:  w = uc_word(MS_NONE, AO_TILT_OFS, XO_NONE, AX_TILT, JC_NEXT, UPC_NONE, 1'b0,
                         1'b0);
      5'd5:  w = uc_word(MS_Z_RECIP, AO_NONE, XO_NONE, AX_TILT, JC_NEXT, UPC_NONE, 1'b0,
                         1'b0);
      5'd6:  w = uc_word(MS_NONE, AO_NONE, XO_TILT_TGT, AX_TILT, JC_COMP_ON, UPC_QUIET,
                         1'b0, 1'b0);
      5'd7:  w = uc_word(MS_NONE, AO_NONE, XO_LOAD_TGT, AX_PAN, JC_ALWAYS, UPC_EMIT,
                         1'b0, 1'b0);
      // tick entry
      5'd8:  w = uc_word(MS_NONE, AO_NONE, XO_NONE, AX_PAN, JC_COMP_OFF, UPC_QUIET, 1'b0,
                         1'b0);
      // pan lag step
      5'd9:  w = uc_word(MS_NONE, AO_NONE, XO_ABS, AX_PAN, JC_NEXT, UPC_NONE, 1'b0, 1'b0);
      5'd10: w = uc_word(MS_MAG_LO, AO_NONE, XO_NONE, AX_PAN, JC_NEXT, UPC_NONE, 1'b0,
                         1'b0);
      5'd11: w = uc_word(MS_MAG_HI, AO_ROUND, XO_NONE, AX_PAN, JC_NEXT, UPC_NONE, 1'b0,
                         1'b0);
      5'd12: w = uc_word(MS_NONE, AO_ADD_HI, XO_NONE, AX_PAN, JC_NEXT, UPC_NONE, 1'b0,
                         1'b0);
      5'd13: w = uc_word(MS_NONE, AO_NONE, XO_UPDATE, AX_PAN, JC_NEXT, UPC_NONE, 1'b0,
                         1'b0);
      5'd14: w = uc_word(MS_NONE, AO_NONE, XO_OUTPUT, AX_PAN, JC_NEXT, UPC_NONE, 1'b0,
                         1'b0);
      // tilt lag step
      5'd15: w = uc_word(MS_NONE, AO_NONE, XO_ABS, AX_TILT, JC_NEXT, UPC_NONE, 1'b0, 1'b0);
      5'd16: w = uc_word(MS_MAG_LO, AO_NONE, XO_NONE, AX_TILT, JC_NEXT, UPC_NONE, 1'b0,
                         1'b0);
      5'd17: w = uc_word(MS_MAG_HI, AO_ROUND, XO_NONE, AX_TILT, JC_NEXT, UPC_NONE, 1'b0,
                         1'b0);
      5'd18: w = uc_word(MS_NONE, AO_ADD_HI, XO_NONE, AX_TILT, JC_NEXT, UPC_NONE, 1'b0,
                         1'b0);
      5'd19: w = uc_word(MS_NONE, AO_NONE, XO_UPDATE, AX_TILT, JC_NEXT, UPC_NONE, 1'b0,
                         1'b0);
      5'd20: w = uc_word(MS_NONE, AO_NONE, XO_OUTPUT, AX_TILT, JC_NEXT, UPC_NONE, 1'b0,
                         1'b0);
      // hand the result to the output register
      5'd21: w = uc_word(MS_NONE, AO_NONE, XO_NONE, AX_PAN, JC_NEXT, UPC_NONE, 1'b1, 1'b1);
      // end without a result
      default: w = uc_word(MS_NONE, AO_NONE, XO_NONE, AX_PAN, JC_NEXT, UPC_NONE, 1'b0,
                           1'b1);
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/ptlc_if.sv]
// ----------------------------------------------------------------------------
// ptlc_if
// Valid/ready channels of the pan/tilt lag compensator: command items in,
// DMX position results out.
// ----------------------------------------------------------------------------
interface ptlc_in_if
  import ptlc_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ptlc_out_if
  import ptlc_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/pan_tilt_lag_compensator_unit.sv]
// ----------------------------------------------------------------------------
// pan_tilt_lag_compensator_unit
// Moving-head position compensator: scales pan/tilt angles to 16-bit DMX
// targets and drives each axis ahead of a first-order lag estimate.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Transfer carries
//  -------  ---------  ----------------------------------------------------
//  in_i     sink       mode, pan_angle, tilt_angle (move command or tick)
//  out_o    source     pan_value, tilt_value, first_slot
//  cfg      write      cfg_we_i, cfg_idx_i, cfg_wdata_i (no read-back)
//
//  A microcoded sequencer runs each item through one shared 24x24
//  multiplier: a move reaches the result register after its scaling
//  steps (it ends with no result with compensation on), a tick after the
//  pan and tilt lag steps with compensation on (no result with it off).
//  The next item is taken on the cycle after the program finishes; a result
//  waiting on out_o holds the program at its hand-off step only.
//  Reset is asynchronous and active low; no clearing pass is needed.
//
module pan_tilt_lag_compensator_unit
  import ptlc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  ptlc_in_if.sink               in_i,
  ptlc_out_if.source            out_o
);

  localparam int unsigned EST_W = 16 + FRAC_BITS;
  localparam int unsigned ACC_W = EST_W + 17;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // Control state
  state_e           state_q;
  logic [UPC_W-1:0] pc_q, pc_d;
  logic             out_valid_q;
  out_item_t        out_data_q;

  // Configuration
  logic [15:0] amp_q, pan_gain_q, tilt_gain_q;
  logic        comp_en_q;
  logic [8:0]  start_slot_q;

  // Axis state
  logic [15:0]      pan_tgt_q, tilt_tgt_q;
  logic [EST_W-1:0] pan_est_q, tilt_est_q;

  // Datapath
  logic             mode_q;
  logic [13:0]      p_q;
  logic [12:0]      u_q;
  logic [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0] acc_q;
  logic [EST_W-1:0] mag_q;
  logic             neg_q;
  logic [15:0]      res_pan_q, res_tilt_q;

  ucode_t            uc;
  logic              in_xfer, out_xfer, stall, run_en, take_jump;
  logic [13:0]       p_sat;
  logic signed [16:0] t_bias;
  logic [12:0]       u_sat;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod_d;
  logic [PROD_W-1:0] mag_ext;
  logic [15:0]       tgt_sel, gain_sel;
  logic [EST_W-1:0]  est_sel, tfix, step, est_new;
  logic              tgt_ge;
  logic [EST_W:0]    twice, est_ext, diff;
  logic [16:0]       diff_hi;
  logic [15:0]       out_val;

  assign uc       = ucode_rom(pc_q);
  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_valid_q && out_o.ready;
  assign stall    = uc.emit && out_valid_q && !out_o.ready;
  assign run_en   = (state_q == ST_RUN) && !stall;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // Saturate angles on transfer: pan to 0..11520, tilt biased to 0..5760
  always_comb begin
    if (in_i.data.pan_angle < 16'sd0) begin
      p_sat = '0;
    end else if (in_i.data.pan_angle > PAN_ANGLE_MAX) begin
      p_sat = PAN_ANGLE_MAX[13:0];
    end else begin
      p_sat = in_i.data.pan_angle[13:0];
    end
    t_bias = $signed({in_i.data.tilt_angle[15], in_i.data.tilt_angle}) + TILT_HALF_SPAN;
    if (t_bias < 17'sd0) begin
      u_sat = '0;
    end else if (t_bias > TILT_SPAN) begin
      u_sat = TILT_SPAN[12:0];
    end else begin
      u_sat = t_bias[12:0];
    end
  end

  // Select the axis worked on by the current step
  assign tgt_sel  = uc.axis ? tilt_tgt_q : pan_tgt_q;
  assign est_sel  = uc.axis ? tilt_est_q : pan_est_q;
  assign gain_sel = uc.axis ? tilt_gain_q : pan_gain_q;
  assign tfix     = EST_W'(tgt_sel) << FRAC_BITS;
  assign mag_ext  = PROD_W'(mag_q);

  // Route multiplier operands
  always_comb begin
    case (uc.mul_sel)
      MS_PAN_AMP: begin
        mul_a = MUL_W'(p_q);
        mul_b = MUL_W'(amp_q);
      end
      MS_Y_RECIP: begin
        mul_a = MUL_W'(prod_q[29:8]);
        mul_b = RECIP_45;
      end
      MS_TILT_SCALE: begin
        mul_a = MUL_W'(u_q);
        mul_b = TILT_SCALE;
      end
      MS_Z_RECIP: begin
        mul_a = MUL_W'(acc_q[27:6]);
        mul_b = RECIP_45;
      end
      MS_MAG_LO: begin
        mul_a = mag_ext[MUL_W-1:0];
        mul_b = MUL_W'(gain_sel);
      end
      MS_MAG_HI: begin
        mul_a = mag_ext[PROD_W-1:MUL_W];
        mul_b = MUL_W'(gain_sel);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Estimate step and compensated output
  assign tgt_ge  = (tfix >= est_sel);
  assign step    = acc_q[16 +: EST_W];
  assign est_new = neg_q ? (est_sel - step) : (est_sel + step);
  assign twice   = {tfix, 1'b0};
  assign est_ext = {1'b0, est_sel};
  assign diff    = twice - est_ext;
  assign diff_hi = diff[EST_W:FRAC_BITS];

  always_comb begin
    if (twice <= est_ext) begin
      out_val = '0;
    end else if (diff_hi[16]) begin
      out_val = 16'hFFFF;
    end else begin
      out_val = diff_hi[15:0];
    end
  end

  // Resolve conditional jumps
  always_comb begin
    case (uc.jump)
      JC_ALWAYS:   take_jump = 1'b1;
      JC_TICK:     take_jump = (mode_q == MODE_TICK);
      JC_COMP_ON:  take_jump = comp_en_q;
      JC_COMP_OFF: take_jump = !comp_en_q;
      default:     take_jump = 1'b0;
    endcase
    pc_d = take_jump ? uc.target : pc_q + 1'b1;
  end

  // Hold sequencer state and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // Drop the result once transferred, unless a new one is handed over
      if (out_xfer && !(run_en && uc.emit)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            state_q <= ST_RUN;
            pc_q    <= '0;
          end
        end
        ST_RUN: begin
          if (!stall) begin
            if (uc.emit) begin
              out_valid_q           <= 1'b1;
              out_data_q.pan_value  <= res_pan_q;
              out_data_q.tilt_value <= res_tilt_q;
              out_data_q.first_slot <= start_slot_q;
            end
            if (uc.finish) begin
              state_q <= ST_IDLE;
            end else begin
              pc_q <= pc_d;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Write configuration registers; drop writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q        <= 16'd65535;
      pan_gain_q   <= 16'd6554;
      tilt_gain_q  <= 16'd6554;
      comp_en_q    <= 1'b1;
      start_slot_q <= 9'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PAN_AMPLITUDE: amp_q        <= cfg_wdata_i;
        CFG_PAN_GAIN:      pan_gain_q   <= cfg_wdata_i;
        CFG_TILT_GAIN:     tilt_gain_q  <= cfg_wdata_i;
        CFG_COMP_ENABLE:   comp_en_q    <= cfg_wdata_i[0];
        CFG_START_SLOT:    start_slot_q <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  // Advance targets and lag estimates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_tgt_q  <= '0;
      tilt_tgt_q <= TILT_CENTRE;
      pan_est_q  <= '0;
      tilt_est_q <= '0;
    end else if (run_en) begin
      case (uc.ex_op)
        XO_PAN_TGT:  pan_tgt_q  <= prod_q[RECIP_SHIFT +: 16];
        XO_TILT_TGT: tilt_tgt_q <= prod_q[RECIP_SHIFT +: 16];
        XO_UPDATE: begin
          if (uc.axis == AX_TILT) begin
            tilt_est_q <= est_new;
          end else begin
            pan_est_q <= est_new;
          end
        end
        default: ;
      endcase
    end
  end

  // Capture the item and run the shared datapath
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q <= in_i.data.mode;
      p_q    <= p_sat;
      u_q    <= u_sat;
    end
    if (run_en) begin
      if (uc.mul_sel != MS_NONE) begin
        prod_q <= prod_d;
      end
      case (uc.acc_op)
        AO_TILT_OFS: acc_q <= ACC_W'(prod_q) + ACC_W'(TILT_OFFSET);
        AO_ROUND:    acc_q <= ACC_W'(prod_q) + ACC_W'(ROUND_HALF);
        AO_ADD_HI:   acc_q <= acc_q + (ACC_W'(prod_q) << MUL_W);
        default: ;
      endcase
      case (uc.ex_op)
        XO_ABS: begin
          mag_q <= tgt_ge ? (tfix - est_sel) : (est_sel - tfix);
          neg_q <= !tgt_ge;
        end
        XO_OUTPUT: begin
          if (uc.axis == AX_TILT) begin
            res_tilt_q <= out_val;
          end else begin
            res_pan_q <= out_val;
          end
        end
        XO_LOAD_TGT: begin
          res_pan_q  <= pan_tgt_q;
          res_tilt_q <= tilt_tgt_q;
        end
        default: ;
      endcase
    end
  end

endmodule

[tb/ptlc_position_checker.sv]
// ----------------------------------------------------------------------------
// ptlc_position_checker
// Watches the command, result and register-write ports of the pan/tilt lag
// compensator. It predicts each DMX position result from its own copy of the
// targets, lag estimates and registers, then compares every result transfer
// field by field with the oldest prediction still due.
// ----------------------------------------------------------------------------
module ptlc_position_checker
  import ptlc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_item_t             out_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned EST_W = 16 + FRAC_BITS;

  // Register copies
  logic [15:0] pan_amp;
  logic [15:0] axis_gain [2];
  logic        comp_on;
  logic [8:0]  slot;

  // Targets and lag estimates, indexed by axis
  logic [15:0]      axis_target [2];
  logic [EST_W-1:0] lag_est [2];

  out_item_t   due_positions [$];
  int unsigned fails;

  // Saturate the pan angle and scale it by the configured amplitude
  function automatic logic [15:0] scale_pan(logic signed [15:0] angle);
    int p;
    p = angle;
    if (p < 0) p = 0;
    else if (p > PAN_ANGLE_MAX) p = PAN_ANGLE_MAX;
    return 16'((longint'(p) * longint'(pan_amp)) / longint'(PAN_ANGLE_MAX));
  endfunction

  // Saturate the tilt angle to +/-90 degrees and map it around the centre
  function automatic logic [15:0] scale_tilt(logic signed [15:0] angle);
    int t;
    int span;
    span = int'(TILT_HALF_SPAN);
    t = angle;
    if (t < -span) t = -span;
    else if (t > span) t = span;
    return 16'((int'(TILT_CENTRE) * span + t * int'(TILT_SCALE)) / span);
  endfunction

  // Advance one axis estimate toward its target and return the driven value
  function automatic logic [15:0] lag_advance(logic ax);
    logic [63:0] tfix;
    logic [63:0] est;
    logic [63:0] mag;
    logic [63:0] stp;
    logic [63:0] twice;
    tfix = 64'(axis_target[ax]) << FRAC_BITS;
    est  = 64'(lag_est[ax]);
    if (tfix >= est) begin
      mag = tfix - est;
      stp = (mag * 64'(axis_gain[ax]) + 64'(ROUND_HALF)) >> 16;
      est = est + stp;
    end else begin
      mag = est - tfix;
      stp = (mag * 64'(axis_gain[ax]) + 64'(ROUND_HALF)) >> 16;
      est = est - stp;
    end
    lag_est[ax] = est[EST_W-1:0];
    twice = tfix << 1;
    if (twice <= est) return 16'd0;
    mag = (twice - est) >> FRAC_BITS;
    return (mag > 64'd65535) ? 16'hFFFF : mag[15:0];
  endfunction

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    out_item_t res;
    logic      emit;
    if (!rst_ni) begin
      pan_amp              = 16'd65535;
      axis_gain[AX_PAN]    = 16'd6554;
      axis_gain[AX_TILT]   = 16'd6554;
      comp_on              = 1'b1;
      slot                 = 9'd1;
      axis_target[AX_PAN]  = 16'd0;
      axis_target[AX_TILT] = TILT_CENTRE;
      lag_est[AX_PAN]      = '0;
      lag_est[AX_TILT]     = '0;
      due_positions.delete();
      fails                = 0;
      fail_count_o        <= 0;
      pending_o           <= 0;
    end else begin
      // Retire a result transfer against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (due_positions.size() == 0) begin
          $error("result transfer with none due: pan %0d tilt %0d slot %0d",
                 out_data_i.pan_value, out_data_i.tilt_value, out_data_i.first_slot);
          fails++;
        end else begin
          want = due_positions.pop_front();
          compare_field("pan_value", want.pan_value, out_data_i.pan_value);
          compare_field("tilt_value", want.tilt_value, out_data_i.tilt_value);
          compare_field("first_slot", want.first_slot, out_data_i.first_slot);
        end
      end

      // Predict the outcome of a command transfer
      if (in_valid_i && in_ready_i) begin
        emit = 1'b0;
        res  = '0;
        if (in_data_i.mode == MODE_MOVE) begin
          axis_target[AX_PAN]  = scale_pan(in_data_i.pan_angle);
          axis_target[AX_TILT] = scale_tilt(in_data_i.tilt_angle);
          if (!comp_on) begin
            res.pan_value  = axis_target[AX_PAN];
            res.tilt_value = axis_target[AX_TILT];
            emit           = 1'b1;
          end
        end else if (comp_on) begin
          res.pan_value  = lag_advance(AX_PAN);
          res.tilt_value = lag_advance(AX_TILT);
          emit           = 1'b1;
        end
        if (emit) begin
          res.first_slot = slot;
          due_positions.push_back(res);
        end
      end

      // Track register writes; spare indexes are dropped
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PAN_AMPLITUDE: pan_amp = cfg_wdata_i;
          CFG_PAN_GAIN:      axis_gain[AX_PAN] = cfg_wdata_i;
          CFG_TILT_GAIN:     axis_gain[AX_TILT] = cfg_wdata_i;
          CFG_COMP_ENABLE:   comp_on = cfg_wdata_i[0];
          CFG_START_SLOT:    slot = cfg_wdata_i[8:0];
          default: ;
        endcase
      end

      fail_count_o <= fails;
      pending_o    <= due_positions.size();
    end
  end

endmodule

[tb/tb_pan_tilt_lag_compensator_unit.sv]
// ----------------------------------------------------------------------------
// tb_pan_tilt_lag_compensator_unit
// Drives move commands and compensation ticks into the compensator under a
// series of register settings, with random gaps on the command side and
// random stalls on the result side. The position checker beside the block
// predicts and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_pan_tilt_lag_compensator_unit;
  import ptlc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC_BITS       = 16;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned PHASE_ITEMS     = 52;
  localparam int unsigned CFG_SPARE_FIRST = CFG_START_SLOT + 1;
  localparam int unsigned CFG_SPARE_LAST  = (1 << CFG_IDX_W) - 1;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned items_taken;
  logic        steady_run = 1'b0;

  ptlc_in_if  in_ch ();
  ptlc_out_if out_ch ();

  pan_tilt_lag_compensator_unit #(
    .FRAC_BITS (FRAC_BITS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  ptlc_position_checker #(
    .FRAC_BITS (FRAC_BITS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_data_i    (in_ch.data),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_data_i   (out_ch.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[pan_tilt_lag_compensator_unit] ERROR");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_run || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Result side: stretches of ready broken by random stalls
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      stall = ($urandom_range(0, 3) == 0) ? 0 : pick_gap();
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Offer one command, hold it until the transfer, then maybe idle
  task automatic offer_command(in_item_t it);
    int unsigned gap;
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    items_taken++;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_command(logic m, int pan, int tilt);
    in_item_t it;
    it.mode       = m;
    it.pan_angle  = 16'(pan);
    it.tilt_angle = 16'(tilt);
    offer_command(it);
  endtask

  // Move angles: mostly in range, some anywhere in the 16-bit field
  function automatic in_item_t random_move();
    in_item_t it;
    it.mode = MODE_MOVE;
    if ($urandom_range(0, 4) == 0) begin
      it.pan_angle  = 16'($urandom);
      it.tilt_angle = 16'($urandom);
    end else begin
      it.pan_angle  = 16'($urandom_range(0, 11520));
      it.tilt_angle = 16'(int'($urandom_range(0, 5760)) - 2880);
    end
    return it;
  endfunction

  // Drop the command valid and wait until the block has gone quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
  endtask

  // Write every register, then a spare index that must be ignored
  task automatic apply_settings(logic [15:0] amp, logic [15:0] pg, logic [15:0] tg,
                                logic en, logic [8:0] slot);
    cfg_write(CFG_PAN_AMPLITUDE, amp);
    cfg_write(CFG_PAN_GAIN, pg);
    cfg_write(CFG_TILT_GAIN, tg);
    cfg_write(CFG_COMP_ENABLE, (16'($urandom) & 16'hFFFE) | 16'(en));
    cfg_write(CFG_START_SLOT, {7'($urandom), slot});
    cfg_write(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), 16'($urandom));
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [15:0] random_gain();
    if ($urandom_range(0, 1) == 0) return 16'($urandom_range(100, 20000));
    return 16'($urandom);
  endfunction

  initial begin : stimulus
    logic [15:0] amp;
    logic [15:0] pg;
    logic [15:0] tg;
    logic        en;
    logic [8:0]  slot;
    in_item_t    it;
    int unsigned ticks;

    rst_ni      <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_idx     <= CFG_PAN_AMPLITUDE;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    items_taken  = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: tick from reset state, then saturated extremes
    send_command(MODE_TICK, 0, 0);
    send_command(MODE_MOVE, 32767, 32767);
    repeat (3) send_command(MODE_TICK, 0, 0);
    send_command(MODE_MOVE, -32768, -32768);
    repeat (2) send_command(MODE_TICK, -1, -1);
    send_command(MODE_MOVE, 11520, -2880);
    send_command(MODE_TICK, 32767, -32768);

    // Compensation off: moves emit at once, a tick is dropped
    settle();
    cfg_write(CFG_COMP_ENABLE, '0);
    cfg_we  <= 1'b0;
    send_command(MODE_MOVE, 0, 0);
    send_command(MODE_MOVE, 11521, 2881);
    send_command(MODE_MOVE, -1, -2881);
    send_command(MODE_MOVE, 11519, 2879);
    send_command(MODE_TICK, 0, 0);

    // Back on with full gain: estimates resume from their old values
    settle();
    cfg_write(CFG_COMP_ENABLE, 16'd1);
    cfg_write(CFG_PAN_GAIN, 16'hFFFF);
    cfg_write(CFG_TILT_GAIN, 16'hFFFF);
    cfg_we  <= 1'b0;
    repeat (2) send_command(MODE_TICK, 0, 0);

    // Random phases, extremes of the registers in the first few
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      settle();
      amp  = 16'($urandom);
      pg   = random_gain();
      tg   = random_gain();
      en   = ($urandom_range(0, 3) != 0);
      slot = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(1, 509));
      case (phase)
        0: begin
          amp  = 16'd0;
          pg   = 16'd0;
          tg   = 16'd0;
          en   = 1'b1;
          slot = 9'd0;
        end
        1: begin
          amp  = 16'hFFFF;
          pg   = 16'hFFFF;
          tg   = 16'hFFFF;
          en   = 1'b1;
          slot = 9'd511;
        end
        2: begin
          en   = 1'b0;
          slot = 9'd509;
        end
        3: begin
          pg   = 16'd1;
          tg   = 16'd1;
          en   = 1'b1;
          slot = 9'd1;
        end
        default: ;
      endcase
      apply_settings(amp, pg, tg, en, slot);
      steady_run  = (phase == 3);
      items_taken = 0;
      while (items_taken < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 15) begin
          // Noise: any mode, any angles
          it.mode       = 1'($urandom);
          it.pan_angle  = 16'($urandom);
          it.tilt_angle = 16'($urandom);
          offer_command(it);
        end else begin
          // A move followed by a run of ticks chasing it
          offer_command(random_move());
          ticks = $urandom_range(1, 8);
          repeat (ticks) send_command(MODE_TICK, int'($urandom), int'($urandom));
        end
      end
      steady_run = 1'b0;
    end

    // Drain and give the verdict
    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("[pan_tilt_lag_compensator_unit] OK");
    end else begin
      $display("[pan_tilt_lag_compensator_unit] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/ptlc_pkg.sv
hw/rtl/ptlc_if.sv
hw/rtl/pan_tilt_lag_compensator_unit.sv
tb/ptlc_position_checker.sv
tb/tb_pan_tilt_lag_compensator_unit.sv
